/* design/tlrg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlrg_pkg
// Shared types, Q30 constants and configuration register indexes of the
// thin-lens ray generator.
// ----------------------------------------------------------------------------
package tlrg_pkg;

    typedef enum logic [1:0] {
        CFG_FOV      = 2'd0,
        CFG_APERTURE = 2'd1,
        CFG_FOCUS    = 2'd2
    } t_cfg_idx;

    localparam logic [15:0] FOV_RESET      = 16'd4211;
    localparam logic [15:0] APERTURE_RESET = 16'd5120;
    localparam logic [23:0] FOCUS_RESET    = 24'd25600;

    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic [29:0] Q30_PI4 = 30'd843314857;

    // ceil(2^36 / d): exact floor division by d for any 30-bit value
    localparam logic [33:0] RC_6  = 34'(((64'd1 << 36) + 64'd5)  / 64'd6);
    localparam logic [33:0] RC_12 = 34'(((64'd1 << 36) + 64'd11) / 64'd12);
    localparam logic [33:0] RC_20 = 34'(((64'd1 << 36) + 64'd19) / 64'd20);
    localparam logic [33:0] RC_30 = 34'(((64'd1 << 36) + 64'd29) / 64'd30);
    localparam logic [33:0] RC_42 = 34'(((64'd1 << 36) + 64'd41) / 64'd42);
    localparam logic [33:0] RC_56 = 34'(((64'd1 << 36) + 64'd55) / 64'd56);

    localparam int DIV_STEPS  = 17;
    localparam int SQRT_STEPS = 32;
    localparam int NRM_STEPS  = 15;
    localparam int LAST_STAGE = 83;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               na;
        logic               nb;
        logic               sel;
        logic               zero;
        logic               nz;
        logic [16:0]        r;
    } t_side;

    typedef struct packed {
        logic [29:0] m0;
        logic [29:0] m1;
        logic [29:0] m2;
        logic        ng0;
        logic        ng1;
        logic        zf;
    } t_nrm;

    function automatic logic [15:0] sat_coord(input logic [17:0] mag, input logic neg);
        logic [15:0] res;
        if (neg) begin
            res = (mag > 18'd32768) ? 16'h8000 : 16'(18'd0 - mag);
        end else begin
            res = (mag > 18'd32767) ? 16'h7FFF : mag[15:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* design/thin_lens_ray_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thin_lens_ray_generator
// Thin-lens camera ray: concentric disk lens point and normalised direction
// towards the focus plane.
// ----------------------------------------------------------------------------
// One request enters per clock and its ray leaves at the end of the pipeline; a
// stall on the output freezes the whole pipeline. The pipeline holds the 17-stage
// ratio divider of the disk mapping, the Taylor sine and cosine chain, the
// 32-stage square root of the direction length and the 15-stage dividers that
// normalise the direction. Configuration writes are always ready.
module thin_lens_ray_generator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_screen_x,
    input  wire logic signed [15:0] i_screen_y,
    input  wire logic [15:0]        i_lens_u,
    input  wire logic [15:0]        i_lens_v,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_origin_x,
    output logic signed [15:0]      o_origin_y,
    output logic signed [15:0]      o_dir_x,
    output logic signed [15:0]      o_dir_y,
    output logic signed [15:0]      o_dir_z,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);

    logic        en;
    logic [15:0] r_fov;
    logic [15:0] r_ap;
    logic [23:0] r_fd;
    logic        r_vld [0:tlrg_pkg::LAST_STAGE];

    // stage 0 and ratio divider
    tlrg_pkg::t_side r_sd [0:26];
    logic [17:0]     r_rm [0:17];
    logic [16:0]     r_qt [0:17];
    logic [17:0]     n_rm [1:17];
    logic [16:0]     n_qt [1:17];
    logic [16:0]     c_ma, c_mb, c_u2, c_v2;
    logic            c_sel;

    // trig chain
    logic [29:0] r_xa  [18:24];
    logic [29:0] r_x2a [19:24];
    logic [29:0] r_ds20, r_dc20, r_ps21, r_pc21, r_ds22, r_dc22;
    logic [29:0] r_ps23, r_pc23, r_ds24, r_dc24, r_sn25, r_pc25, r_sn26;
    logic [30:0] r_cs26;

    // lens point and screen products
    logic [30:0]        r_ux, r_uy;
    logic signed [32:0] r_stx, r_sty;
    logic               r_sgx, r_sgy, r_zr;
    logic signed [15:0] r_ox, r_oy;
    logic signed [57:0] r_px, r_py;
    logic [31:0]        r_og [29:82];
    logic [30:0]        c_tx, c_ty;
    logic               c_tn;
    logic [17:0]        c_magx, c_magy;

    // difference vector and normalisation
    logic signed [57:0] c_dx, c_dy;
    logic [56:0] r_mv  [29:31][0:2];
    logic        r_ngv [29:31][0:1];
    logic [56:0] r_mx30;
    logic [5:0]  r_p31;
    logic        r_zf31;
    logic [5:0]  c_p;
    tlrg_pkg::t_nrm r_nm [32:66];
    logic [56:0] c_sh [0:2];
    logic [59:0] r_sq [0:2];

    // square root
    logic [63:0] r_sn [0:32];
    logic [63:0] r_sr [0:32];
    logic [63:0] n_sn [1:32];
    logic [63:0] n_sr [1:32];
    logic [63:0] v_bit, v_t;

    // direction dividers
    logic [31:0] r_dr [0:15][0:2];
    logic [14:0] r_dl [0:15][0:2];
    logic [14:0] r_dq [0:15][0:2];
    logic [31:0] r_ln [0:15];
    logic [2:0]  r_fl [0:15];
    logic [31:0] n_dr [1:15][0:2];
    logic [14:0] n_dl [1:15][0:2];
    logic [14:0] n_dq [1:15][0:2];
    logic [32:0] v_num;
    logic        v_ge;
    logic [44:0] c_n [0:2];
    logic [14:0] c_q [0:2];

    assign en          = !(r_vld[tlrg_pkg::LAST_STAGE] && i_out_stall);
    assign o_in_stall  = !en || !i_rst_n;
    assign o_out_valid = r_vld[tlrg_pkg::LAST_STAGE];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fov <= tlrg_pkg::FOV_RESET;
            r_ap  <= tlrg_pkg::APERTURE_RESET;
            r_fd  <= tlrg_pkg::FOCUS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlrg_pkg::CFG_FOV:      r_fov <= i_cfg_data[15:0];
                tlrg_pkg::CFG_APERTURE: r_ap  <= i_cfg_data[15:0];
                tlrg_pkg::CFG_FOCUS:    r_fd  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= tlrg_pkg::LAST_STAGE; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k <= tlrg_pkg::LAST_STAGE; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 0: fold the lens sample about the centre
    always_comb begin
        c_u2  = {i_lens_u, 1'b0};
        c_v2  = {i_lens_v, 1'b0};
        c_ma  = i_lens_u[15] ? c_u2 - 17'd65536 : 17'd65536 - c_u2;
        c_mb  = i_lens_v[15] ? c_v2 - 17'd65536 : 17'd65536 - c_v2;
        c_sel = c_ma > c_mb;
    end

    always_comb begin
        logic [17:0] rin;
        logic [17:0] den;
        rin = '0;
        den = '0;
        for (int k = 1; k <= tlrg_pkg::DIV_STEPS; k++) begin
            rin = (k == 1) ? r_rm[0] : {r_rm[k-1][16:0], 1'b0};
            den = {1'b0, r_sd[k-1].r};
            if (rin >= den) begin
                n_rm[k] = rin - den;
                n_qt[k] = {r_qt[k-1][15:0], 1'b1};
            end else begin
                n_rm[k] = rin;
                n_qt[k] = {r_qt[k-1][15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0].sx   <= i_screen_x;
            r_sd[0].sy   <= i_screen_y;
            r_sd[0].na   <= ~i_lens_u[15];
            r_sd[0].nb   <= ~i_lens_v[15];
            r_sd[0].sel  <= c_sel;
            r_sd[0].zero <= !c_sel && (c_mb == 17'd0);
            r_sd[0].nz   <= (c_sel ? c_mb : c_ma) != 17'd0;
            r_sd[0].r    <= c_sel ? c_ma : c_mb;
            r_rm[0]      <= {1'b0, (c_sel ? c_mb : c_ma)};
            r_qt[0]      <= '0;
            for (int k = 1; k <= 26; k++) r_sd[k] <= r_sd[k-1];
            for (int k = 1; k <= tlrg_pkg::DIV_STEPS; k++) begin
                r_rm[k] <= n_rm[k];
                r_qt[k] <= n_qt[k];
            end
        end
    end

    // sine and cosine in Q30
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xa[18] <= 30'((64'(r_qt[17]) * 64'(tlrg_pkg::Q30_PI4)) >> 16);
            for (int k = 19; k <= 24; k++) r_xa[k] <= r_xa[k-1];
            r_x2a[19] <= 30'((64'(r_xa[18]) * 64'(r_xa[18])) >> 30);
            for (int k = 20; k <= 24; k++) r_x2a[k] <= r_x2a[k-1];
            r_ds20 <= 30'((64'(r_x2a[19]) * 64'(tlrg_pkg::RC_42)) >> 36);
            r_dc20 <= 30'((64'(r_x2a[19]) * 64'(tlrg_pkg::RC_56)) >> 36);
            r_ps21 <= 30'((64'(r_x2a[20]) * 64'(tlrg_pkg::Q30_ONE - 31'(r_ds20))) >> 30);
            r_pc21 <= 30'((64'(r_x2a[20]) * 64'(tlrg_pkg::Q30_ONE - 31'(r_dc20))) >> 30);
            r_ds22 <= 30'((64'(r_ps21) * 64'(tlrg_pkg::RC_20)) >> 36);
            r_dc22 <= 30'((64'(r_pc21) * 64'(tlrg_pkg::RC_30)) >> 36);
            r_ps23 <= 30'((64'(r_x2a[22]) * 64'(tlrg_pkg::Q30_ONE - 31'(r_ds22))) >> 30);
            r_pc23 <= 30'((64'(r_x2a[22]) * 64'(tlrg_pkg::Q30_ONE - 31'(r_dc22))) >> 30);
            r_ds24 <= 30'((64'(r_ps23) * 64'(tlrg_pkg::RC_6)) >> 36);
            r_dc24 <= 30'((64'(r_pc23) * 64'(tlrg_pkg::RC_12)) >> 36);
            r_sn25 <= 30'((64'(r_xa[24]) * 64'(tlrg_pkg::Q30_ONE - 31'(r_ds24))) >> 30);
            r_pc25 <= 30'((64'(r_x2a[24]) * 64'(tlrg_pkg::Q30_ONE - 31'(r_dc24))) >> 30);
            r_sn26 <= r_sn25;
            r_cs26 <= tlrg_pkg::Q30_ONE - 31'(r_pc25 >> 1);
        end
    end

    // lens point on the disk, scaled by the aperture
    always_comb begin
        c_tn   = (r_sd[26].na ^ r_sd[26].nb) & r_sd[26].nz;
        c_tx   = r_sd[26].sel ? r_cs26 : {1'b0, r_sn26};
        c_ty   = r_sd[26].sel ? {1'b0, r_sn26} : r_cs26;
        c_magx = 18'(((64'(r_ux) * 64'(r_ap)) + 64'd536870912) >> 30);
        c_magy = 18'(((64'(r_uy) * 64'(r_ap)) + 64'd536870912) >> 30);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ux  <= 31'((64'(r_sd[26].r) * 64'(c_tx)) >> 16);
            r_uy  <= 31'((64'(r_sd[26].r) * 64'(c_ty)) >> 16);
            r_stx <= 33'(r_sd[26].sx) * $signed({17'd0, r_fov});
            r_sty <= 33'(r_sd[26].sy) * $signed({17'd0, r_fov});
            r_sgx <= r_sd[26].sel ? r_sd[26].na : r_sd[26].nb ^ c_tn;
            r_sgy <= r_sd[26].sel ? r_sd[26].na ^ c_tn : r_sd[26].nb;
            r_zr  <= r_sd[26].zero;
            r_ox  <= r_zr ? 16'sd0 : $signed(tlrg_pkg::sat_coord(c_magx, r_sgx));
            r_oy  <= r_zr ? 16'sd0 : $signed(tlrg_pkg::sat_coord(c_magy, r_sgy));
            r_px  <= 58'(r_stx) * $signed(58'({1'b0, r_fd}));
            r_py  <= 58'(r_sty) * $signed(58'({1'b0, r_fd}));
            r_og[29] <= {r_ox, r_oy};
            for (int k = 30; k <= 82; k++) r_og[k] <= r_og[k-1];
        end
    end

    // difference vector, largest magnitude and normalising shift
    always_comb begin
        c_dx = r_px - (58'(r_ox) <<< 22);
        c_dy = r_py - (58'(r_oy) <<< 22);
        c_p  = '0;
        for (int i = 0; i < 57; i++) begin
            if (r_mx30[i]) c_p = 6'(i);
        end
        for (int i = 0; i < 3; i++) begin
            c_sh[i] = (r_p31 > 6'd29) ? r_mv[31][i] >> (r_p31 - 6'd29)
                                      : r_mv[31][i] << (6'd29 - r_p31);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mv[29][0]  <= c_dx[57] ? 57'(-c_dx) : 57'(c_dx);
            r_mv[29][1]  <= c_dy[57] ? 57'(-c_dy) : 57'(c_dy);
            r_mv[29][2]  <= 57'({r_fd, 26'd0});
            r_ngv[29][0] <= c_dx[57];
            r_ngv[29][1] <= c_dy[57];
            for (int k = 30; k <= 31; k++) begin
                r_mv[k]  <= r_mv[k-1];
                r_ngv[k] <= r_ngv[k-1];
            end
            if (r_mv[29][0] >= r_mv[29][1] && r_mv[29][0] >= r_mv[29][2]) begin
                r_mx30 <= r_mv[29][0];
            end else if (r_mv[29][1] >= r_mv[29][2]) begin
                r_mx30 <= r_mv[29][1];
            end else begin
                r_mx30 <= r_mv[29][2];
            end
            r_p31  <= c_p;
            r_zf31 <= r_mx30 == 57'd0;
            r_nm[32].m0  <= c_sh[0][29:0];
            r_nm[32].m1  <= c_sh[1][29:0];
            r_nm[32].m2  <= c_sh[2][29:0];
            r_nm[32].ng0 <= r_ngv[31][0];
            r_nm[32].ng1 <= r_ngv[31][1];
            r_nm[32].zf  <= r_zf31;
            for (int k = 33; k <= 66; k++) r_nm[k] <= r_nm[k-1];
            r_sq[0] <= 60'(64'(r_nm[32].m0) * 64'(r_nm[32].m0));
            r_sq[1] <= 60'(64'(r_nm[32].m1) * 64'(r_nm[32].m1));
            r_sq[2] <= 60'(64'(r_nm[32].m2) * 64'(r_nm[32].m2));
        end
    end

    // integer square root, one result bit a stage
    always_comb begin
        v_bit = '0;
        v_t   = '0;
        for (int k = 1; k <= tlrg_pkg::SQRT_STEPS; k++) begin
            v_bit = 64'd1 << (64 - 2 * k);
            v_t   = r_sr[k-1] + v_bit;
            if (r_sn[k-1] >= v_t) begin
                n_sn[k] = r_sn[k-1] - v_t;
                n_sr[k] = (r_sr[k-1] >> 1) + v_bit;
            end else begin
                n_sn[k] = r_sn[k-1];
                n_sr[k] = r_sr[k-1] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sn[0] <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
            r_sr[0] <= '0;
            for (int k = 1; k <= tlrg_pkg::SQRT_STEPS; k++) begin
                r_sn[k] <= n_sn[k];
                r_sr[k] <= n_sr[k];
            end
        end
    end

    // component / length with rounding, one quotient bit a stage
    always_comb begin
        c_n[0] = 45'(64'(r_nm[66].m0) << 14) + 45'(r_sr[32][31:1]);
        c_n[1] = 45'(64'(r_nm[66].m1) << 14) + 45'(r_sr[32][31:1]);
        c_n[2] = 45'(64'(r_nm[66].m2) << 14) + 45'(r_sr[32][31:1]);
        v_num  = '0;
        v_ge   = 1'b0;
        for (int j = 1; j <= tlrg_pkg::NRM_STEPS; j++) begin
            for (int i = 0; i < 3; i++) begin
                v_num      = {r_dr[j-1][i], r_dl[j-1][i][14]};
                v_ge       = v_num >= {1'b0, r_ln[j-1]};
                n_dr[j][i] = v_ge ? 32'(v_num - {1'b0, r_ln[j-1]}) : 32'(v_num);
                n_dl[j][i] = {r_dl[j-1][i][13:0], 1'b0};
                n_dq[j][i] = {r_dq[j-1][i][13:0], v_ge};
            end
        end
        for (int i = 0; i < 3; i++) begin
            c_q[i] = (r_dq[15][i] > 15'd16384) ? 15'd16384 : r_dq[15][i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_dr[0][i] <= 32'(c_n[i][44:15]);
                r_dl[0][i] <= c_n[i][14:0];
                r_dq[0][i] <= '0;
            end
            r_ln[0] <= r_sr[32][31:0];
            r_fl[0] <= {r_nm[66].ng0, r_nm[66].ng1, r_nm[66].zf};
            for (int j = 1; j <= tlrg_pkg::NRM_STEPS; j++) begin
                r_dr[j] <= n_dr[j];
                r_dl[j] <= n_dl[j];
                r_dq[j] <= n_dq[j];
                r_ln[j] <= r_ln[j-1];
                r_fl[j] <= r_fl[j-1];
            end
            o_origin_x <= $signed(r_og[82][31:16]);
            o_origin_y <= $signed(r_og[82][15:0]);
            if (r_fl[15][0]) begin
                o_dir_x <= 16'sd0;
                o_dir_y <= 16'sd0;
                o_dir_z <= -16'sd16384;
            end else begin
                o_dir_x <= r_fl[15][2] ? $signed(16'(16'd0 - {1'b0, c_q[0]}))
                                       : $signed({1'b0, c_q[0]});
                o_dir_y <= r_fl[15][1] ? $signed(16'(16'd0 - {1'b0, c_q[1]}))
                                       : $signed({1'b0, c_q[1]});
                o_dir_z <= $signed(16'(16'd0 - {1'b0, c_q[2]}));
            end
        end
    end

`ifndef ASSERT_OFF
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_in_valid && !o_in_stall) |-> r_vld[0])
        else $error("accepted request not captured");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(r_vld[0]) && $stable(r_vld[41]))
        else $error("pipeline advanced under stall");
    a_dir_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dir_z[15] || o_dir_z == 16'sd0))
        else $error("direction z not towards the scene");
    a_dir_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dir_x >= -16'sd16384 && o_dir_x <= 16'sd16384 &&
                         o_dir_y >= -16'sd16384 && o_dir_y <= 16'sd16384))
        else $error("direction component out of range");
`endif

endmodule
`default_nettype wire
